FILE: design/dlfr_pkg.sv
package dlfr_pkg;

	// Field widths
	localparam int WORD_W    = 32;
	localparam int POS_W     = 10;
	localparam int RES_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int LEFT_W    = 9;
	localparam int TOP_W     = 8;
	localparam int COLOR_W   = 16;
	localparam int TOTAL_W   = 17;
	localparam int RGBA_W    = 16;
	localparam int PRIM_W    = 24;
	localparam int OP_W      = 8;

	// Command codes
	localparam logic [WORD_W-1:0] CYCLE_WORD     = 32'hE300_0A01;
	localparam logic [WORD_W-1:0] CYCLE_FILL     = 32'h0030_0000;
	localparam logic [OP_W-1:0]   OP_FILL_COLOR  = 8'hF7;
	localparam logic [OP_W-1:0]   OP_PRIM_COLOR  = 8'hFA;
	localparam logic [OP_W-1:0]   OP_FILL_RECT   = 8'hF6;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;
	localparam logic [RES_W-1:0]     SOURCE_WIDTH_RST  = 10'd320;
	localparam logic [RES_W-1:0]     SOURCE_HEIGHT_RST = 10'd240;

	// Controller to datapath commands
	typedef struct packed {
		logic       accept;
		logic       load;
		logic       step;
		logic       store;
		logic       clip;
		logic       emit;
		logic [1:0] corner;
	} dlfr_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_rect;
		logic empty;
	} dlfr_sts_t;

	// RGBA5551 fill color to opaque BGR555
	function automatic logic [COLOR_W-1:0] color_from_fill(input logic [RGBA_W-1:0] c);
		return {1'b1, c[5:1], c[10:6], c[15:11]};
	endfunction

	// 8-bit primitive RGB to opaque BGR555
	function automatic logic [COLOR_W-1:0] color_from_prim(input logic [PRIM_W-1:0] p);
		return {1'b1, p[7:3], p[15:11], p[23:19]};
	endfunction

endpackage

FILE: design/dlfr_if.sv
interface dlfr_cmd_if;
	import dlfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_high;
	logic [WORD_W-1:0] word_low;
	modport source(output valid, word_high, word_low, input ready);
	modport sink(input valid, word_high, word_low, output ready);
endinterface

interface dlfr_res_if;
	import dlfr_pkg::*;
	logic               valid;
	logic               ready;
	logic [LEFT_W-1:0]  left;
	logic [TOP_W-1:0]   top;
	logic [LEFT_W-1:0]  right;
	logic [TOP_W-1:0]   bottom;
	logic [COLOR_W-1:0] pixel_color;
	logic [TOTAL_W-1:0] pixel_total;
	modport source(output valid, left, top, right, bottom, pixel_color, pixel_total,
		input ready);
	modport sink(input valid, left, top, right, bottom, pixel_color, pixel_total,
		output ready);
endinterface

interface dlfr_cfg_if;
	import dlfr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RES_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: design/display_list_fill_rect_decoder.sv
// Color and cycle-type commands leave the controller idle; the next item is accepted in the next cycle.
// A fill rectangle runs four corner divides on one shared divider, two quotient bits a
// cycle of a Q-bit quotient (Q is 20 at 320x240); each corner is loaded and divided in
// turn, then the corners are clipped and the result emitted; no item is accepted meanwhile.
// An empty rectangle returns to idle after the clip without an emit; a result still waiting
// for its sink stalls the emit of the next one. Reset is asynchronous, active low; source size resets to
// 320x240, colors and mode clear.
module display_list_fill_rect_decoder #(
	parameter int STAGE_WIDTH  = 320,
	parameter int STAGE_HEIGHT = 240
) (
	input logic       clk,
	input logic       arst_n,
	dlfr_cmd_if.sink  cmd,
	dlfr_res_if.source res,
	dlfr_cfg_if.sink  cfg
);
	import dlfr_pkg::*;

	localparam int STAGE_MAX = (STAGE_WIDTH > STAGE_HEIGHT) ? STAGE_WIDTH : STAGE_HEIGHT;
	localparam int SAW   = $clog2(STAGE_MAX + 1);
	localparam int PW    = POS_W + SAW;
	localparam int QW    = PW + (PW % 2);
	localparam int STEPS = QW / 2;

	dlfr_ctl_t ctl;
	dlfr_sts_t sts;

	// Registers accept writes at any time
	assign cfg.ready = 1'b1;

	dlfr_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	dlfr_dpath #(
		.STAGE_WIDTH  (STAGE_WIDTH),
		.STAGE_HEIGHT (STAGE_HEIGHT)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.word_high       (cmd.word_high),
		.word_low        (cmd.word_low),
		.cfg_write       (cfg.valid && cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.ctl             (ctl),
		.sts             (sts),
		.res_left        (res.left),
		.res_top         (res.top),
		.res_right       (res.right),
		.res_bottom      (res.bottom),
		.res_pixel_color (res.pixel_color),
		.res_pixel_total (res.pixel_total)
	);

endmodule

FILE: design/dlfr_ctrl.sv
module dlfr_ctrl #(
	parameter int STEPS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  dlfr_pkg::dlfr_sts_t sts,
	output dlfr_pkg::dlfr_ctl_t ctl
);
	import dlfr_pkg::*;

	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(STEPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CLIP = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] step_q;
	logic [1:0]       corner_q;
	logic             out_valid_q;

	// Decode commands from state
	always_comb begin
		cmd_ready  = (state_q == ST_IDLE);
		ctl.accept = cmd_valid && cmd_ready;
		ctl.load   = (state_q == ST_LOAD);
		ctl.step   = (state_q == ST_DIV);
		ctl.store  = (state_q == ST_DIV) && (step_q == STEP_LAST);
		ctl.clip   = (state_q == ST_CLIP) && !sts.empty;
		ctl.emit   = (state_q == ST_EMIT) && (!out_valid_q || res_ready);
		ctl.corner = corner_q;
		res_valid  = out_valid_q;
	end

	// Sequence four corner divides, then clip and, unless the rectangle is empty, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			corner_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.accept && sts.is_rect) begin
						state_q  <= ST_LOAD;
						corner_q <= '0;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						if (corner_q == 2'd3) begin
							state_q <= ST_CLIP;
						end else begin
							corner_q <= corner_q + 1'b1;
							state_q  <= ST_LOAD;
						end
					end
				end
				ST_CLIP: begin
					state_q <= sts.empty ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (ctl.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/dlfr_dpath.sv
module dlfr_dpath #(
	parameter int STAGE_WIDTH  = 320,
	parameter int STAGE_HEIGHT = 240
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [dlfr_pkg::WORD_W-1:0]            word_high,
	input  logic [dlfr_pkg::WORD_W-1:0]            word_low,
	input  logic                                   cfg_write,
	input  logic [dlfr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dlfr_pkg::RES_W-1:0]             cfg_data,
	input  dlfr_pkg::dlfr_ctl_t                    ctl,
	output dlfr_pkg::dlfr_sts_t                    sts,
	output logic [dlfr_pkg::LEFT_W-1:0]            res_left,
	output logic [dlfr_pkg::TOP_W-1:0]             res_top,
	output logic [dlfr_pkg::LEFT_W-1:0]            res_right,
	output logic [dlfr_pkg::TOP_W-1:0]             res_bottom,
	output logic [dlfr_pkg::COLOR_W-1:0]           res_pixel_color,
	output logic [dlfr_pkg::TOTAL_W-1:0]           res_pixel_total
);
	import dlfr_pkg::*;

	localparam int STAGE_MAX = (STAGE_WIDTH > STAGE_HEIGHT) ? STAGE_WIDTH : STAGE_HEIGHT;
	localparam int SAW = $clog2(STAGE_MAX + 1);
	localparam int DVW = (SAW > RES_W) ? SAW : RES_W;
	localparam int PW  = POS_W + SAW;
	localparam int QW  = PW + (PW % 2);
	localparam int DW  = SAW + 1;
	localparam int TW  = 2 * DW;

	localparam logic [QW-1:0]  STAGE_X_Q  = QW'(STAGE_WIDTH);
	localparam logic [QW-1:0]  STAGE_Y_Q  = QW'(STAGE_HEIGHT);
	localparam logic [DVW-1:0] STAGE_X_DV = DVW'(STAGE_WIDTH);
	localparam logic [DVW-1:0] STAGE_Y_DV = DVW'(STAGE_HEIGHT);

	// Architectural state
	logic [RES_W-1:0]  src_w_q;
	logic [RES_W-1:0]  src_h_q;
	logic              fill_mode_q;
	logic [RGBA_W-1:0] fill_rgba_q;
	logic [PRIM_W-1:0] prim_rgb_q;

	// Rectangle working registers
	logic [POS_W-1:0] pos_q [4];
	logic [SAW-1:0]   cor_q [4];
	logic [QW-1:0]    num_q;
	logic [DVW-1:0]   rem_q;
	logic [DVW-1:0]   div_q;
	logic [TW-1:0]    total_q;

	logic [OP_W-1:0] op;
	logic            is_cycle;
	logic            axis_y;
	logic [QW-1:0]   stage_sel;
	logic [DVW-1:0]  res_sel;
	logic [QW-1:0]   cap;
	logic [DVW:0]    r1, r2;
	logic [DVW-1:0]  rs1, rs2;
	logic            ge1, ge2;
	logic [QW-1:0]   q_fin;
	logic [DW-1:0]   dx, dy;

	assign op       = word_high[WORD_W-1 -: OP_W];
	assign is_cycle = (word_high == CYCLE_WORD);
	assign sts.is_rect = !is_cycle && (op == OP_FILL_RECT);
	assign sts.empty   = (cor_q[2] < cor_q[0]) || (cor_q[3] < cor_q[1]);

	// Select axis constants for the current corner
	assign axis_y    = ctl.corner[0];
	assign stage_sel = axis_y ? STAGE_Y_Q : STAGE_X_Q;
	always_comb begin
		if (axis_y) begin
			res_sel = (src_h_q == '0) ? STAGE_Y_DV : DVW'(src_h_q);
		end else begin
			res_sel = (src_w_q == '0) ? STAGE_X_DV : DVW'(src_w_q);
		end
		// Upper-left corners cap at the stage size, lower-right at its last index
		cap = ctl.corner[1] ? (stage_sel - 1'b1) : stage_sel;
	end

	// Two restoring divide steps per cycle
	always_comb begin
		r1    = {rem_q, num_q[QW-1]};
		ge1   = (r1 >= {1'b0, div_q});
		rs1   = ge1 ? DVW'(r1 - {1'b0, div_q}) : r1[DVW-1:0];
		r2    = {rs1, num_q[QW-2]};
		ge2   = (r2 >= {1'b0, div_q});
		rs2   = ge2 ? DVW'(r2 - {1'b0, div_q}) : r2[DVW-1:0];
		q_fin = {num_q[QW-3:0], ge1, ge2};
	end

	// Span of the clipped rectangle
	assign dx = DW'(cor_q[2]) - DW'(cor_q[0]) + DW'(1);
	assign dy = DW'(cor_q[3]) - DW'(cor_q[1]) + DW'(1);

	// Configuration and command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= SOURCE_WIDTH_RST;
			src_h_q     <= SOURCE_HEIGHT_RST;
			fill_mode_q <= 1'b0;
			fill_rgba_q <= '0;
			prim_rgb_q  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
					REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.accept) begin
				if (is_cycle) begin
					fill_mode_q <= (word_low == CYCLE_FILL);
				end else if (op == OP_FILL_COLOR) begin
					fill_rgba_q <= word_low[RGBA_W-1:0];
				end else if (op == OP_PRIM_COLOR) begin
					prim_rgb_q <= word_low[WORD_W-1 -: PRIM_W];
				end
			end
		end
	end

	// Latch corners, run the divider, keep clipped corners
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			pos_q[0] <= word_low[23:14];
			pos_q[1] <= word_low[11:2];
			pos_q[2] <= word_high[23:14];
			pos_q[3] <= word_high[11:2];
		end
		if (ctl.load) begin
			num_q <= QW'(pos_q[ctl.corner]) * stage_sel;
			rem_q <= '0;
			div_q <= res_sel;
		end else if (ctl.step) begin
			num_q <= q_fin;
			rem_q <= rs2;
		end
		if (ctl.store) begin
			cor_q[ctl.corner] <= (q_fin > cap) ? SAW'(cap) : SAW'(q_fin);
		end
		if (ctl.clip) begin
			total_q <= TW'(dx) * TW'(dy);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_left        <= LEFT_W'(cor_q[0]);
			res_top         <= TOP_W'(cor_q[1]);
			res_right       <= LEFT_W'(cor_q[2]);
			res_bottom      <= TOP_W'(cor_q[3]);
			res_pixel_total <= TOTAL_W'(total_q);
			res_pixel_color <= fill_mode_q ? color_from_fill(fill_rgba_q)
				: color_from_prim(prim_rgb_q);
		end
	end

endmodule

FILE: design/dlfr_chk.sv
module dlfr_chk (
	input logic        clk,
	input logic        arst_n,
	dlfr_cmd_if.sink   cmd,
	dlfr_res_if.source res
);
	import dlfr_pkg::*;

	logic cmd_acc;
	logic rect_acc;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign rect_acc = cmd_acc && (cmd.word_high != CYCLE_WORD)
		&& (cmd.word_high[WORD_W-1 -: OP_W] == OP_FILL_RECT);

	// A rectangle keeps the block busy for the following cycle
	a_rect_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rect_acc |=> !cmd.ready)
		else $error("ready high right after a rectangle item");

	// Other commands leave the block ready for the next item
	a_cmd_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && !rect_acc) |=> cmd.ready)
		else $error("ready dropped after a non-rectangle item");

	// Every emitted color is opaque
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.pixel_color[COLOR_W-1])
		else $error("result color not opaque");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.pixel_total)
		&& $stable(res.left) && $stable(res.bottom)))
		else $error("stalled result changed");

endmodule

bind display_list_fill_rect_decoder dlfr_chk u_dlfr_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import dlfr_pkg::*;

	localparam int STAGE_W      = 320;
	localparam int STAGE_H      = 240;
	localparam int DRAIN_CYCLES = 150;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_LEN     = 600;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [WORD_W-1:0] word_high;
		logic [WORD_W-1:0] word_low;
	} command_t;

	typedef struct packed {
		logic [LEFT_W-1:0]  left;
		logic [TOP_W-1:0]   top;
		logic [LEFT_W-1:0]  right;
		logic [TOP_W-1:0]   bottom;
		logic [COLOR_W-1:0] pixel_color;
		logic [TOTAL_W-1:0] pixel_total;
	} rect_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dlfr_cmd_if cmd();
	dlfr_res_if res();
	dlfr_cfg_if cfg();

	display_list_fill_rect_decoder #(
		.STAGE_WIDTH(STAGE_W),
		.STAGE_HEIGHT(STAGE_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.cfg(cfg)
	);

	always #5 clk = ~clk;

	// Decoder state as the block should hold it
	logic [RES_W-1:0]  src_width  = SOURCE_WIDTH_RST;
	logic [RES_W-1:0]  src_height = SOURCE_HEIGHT_RST;
	logic              fill_mode  = 1'b0;
	logic [RGBA_W-1:0] fill_rgba  = '0;
	logic [PRIM_W-1:0] prim_rgb   = '0;

	command_t     cmd_queue[$];
	rect_result_t rect_expect[$];
	int           cmd_pushed   = 0;
	int           cmd_accepted = 0;
	int           results_seen = 0;
	int           mismatches   = 0;
	int           pace_max     = 17;
	int           cmd_gap;
	int           res_wait;
	int           hold_cycles;
	bit           hold_done;

	// Map one source coordinate onto the stage; zero resolution is identity
	function automatic int unsigned scale_to_stage(input logic [POS_W-1:0] pos,
			input logic [RES_W-1:0] resolution, input int unsigned stage);
		int unsigned div;
		div = (resolution == '0) ? stage : int'(resolution);
		return (int'(pos) * stage) / div;
	endfunction

	// Apply one command to the mirrored state and queue the rectangle it draws
	function automatic void decode_command(input logic [WORD_W-1:0] hi,
			input logic [WORD_W-1:0] lo);
		int unsigned x0, y0, x1, y1;
		logic [4:0] red, green, blue;
		rect_result_t r;
		if (hi == CYCLE_WORD) begin
			fill_mode = (lo == CYCLE_FILL);
		end else if (hi[31:24] == OP_FILL_COLOR) begin
			fill_rgba = lo[15:0];
		end else if (hi[31:24] == OP_PRIM_COLOR) begin
			prim_rgb = lo[31:8];
		end else if (hi[31:24] == OP_FILL_RECT) begin
			x0 = scale_to_stage(lo[23:14], src_width, STAGE_W);
			y0 = scale_to_stage(lo[11:2], src_height, STAGE_H);
			x1 = scale_to_stage(hi[23:14], src_width, STAGE_W);
			y1 = scale_to_stage(hi[11:2], src_height, STAGE_H);
			if (x1 > STAGE_W - 1)
				x1 = STAGE_W - 1;
			if (y1 > STAGE_H - 1)
				y1 = STAGE_H - 1;
			if (x1 >= x0 && y1 >= y0) begin
				if (fill_mode) begin
					red   = fill_rgba[15:11];
					green = fill_rgba[10:6];
					blue  = fill_rgba[5:1];
				end else begin
					red   = prim_rgb[23:19];
					green = prim_rgb[15:11];
					blue  = prim_rgb[7:3];
				end
				r.left        = x0[LEFT_W-1:0];
				r.top         = y0[TOP_W-1:0];
				r.right       = x1[LEFT_W-1:0];
				r.bottom      = y1[TOP_W-1:0];
				r.pixel_color = {1'b1, blue, green, red};
				r.pixel_total = TOTAL_W'((x1 - x0 + 1) * (y1 - y0 + 1));
				rect_expect.push_back(r);
			end
		end
	endfunction

	function automatic command_t rect_command(input int unsigned lrx, input int unsigned lry,
			input int unsigned ulx, input int unsigned uly, input bit junk);
		command_t c;
		logic [31:0] fill_h, fill_l;
		fill_h = junk ? $urandom : 32'h0;
		fill_l = junk ? $urandom : 32'h0;
		c.word_high = {OP_FILL_RECT, lrx[9:0], fill_h[13:12], lry[9:0], fill_h[1:0]};
		c.word_low  = {fill_l[31:24], ulx[9:0], fill_l[13:12], uly[9:0], fill_l[1:0]};
		return c;
	endfunction

	function automatic command_t random_command(input logic [RES_W-1:0] w,
			input logic [RES_W-1:0] h);
		command_t c;
		int unsigned pick, span_x, span_y, ulx, uly, lrx, lry;
		pick   = $urandom_range(0, 99);
		span_x = (w == '0) ? STAGE_W : int'(w);
		span_y = (h == '0) ? STAGE_H : int'(h);
		c.word_high = $urandom;
		c.word_low  = $urandom;
		if (pick < 45) begin
			// well-formed rectangle, upper-left corner no further out than the source size
			ulx = $urandom_range(0, span_x);
			uly = $urandom_range(0, span_y);
			lrx = $urandom_range(ulx, (ulx + span_x > 1023) ? 1023 : ulx + span_x);
			lry = $urandom_range(uly, (uly + span_y > 1023) ? 1023 : uly + span_y);
			c = rect_command(lrx, lry, ulx, uly, 1'b1);
		end else if (pick < 52) begin
			c = rect_command($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023), 1'b1);
		end else if (pick < 64) begin
			c.word_high[31:24] = OP_PRIM_COLOR;
		end else if (pick < 74) begin
			c.word_high[31:24] = OP_FILL_COLOR;
		end else if (pick < 84) begin
			c.word_high = CYCLE_WORD;
			if ($urandom_range(0, 1))
				c.word_low = CYCLE_FILL;
		end else if (pick < 90) begin
			// near miss of the cycle-type word
			c.word_high = CYCLE_WORD ^ (32'h1 << $urandom_range(0, 23));
			c.word_low  = CYCLE_FILL;
		end
		return c;
	endfunction

	task automatic push_command(input command_t c);
		cmd_queue.push_back(c);
		cmd_pushed++;
	endtask

	task automatic push_random(input int count, input logic [RES_W-1:0] w,
			input logic [RES_W-1:0] h);
		for (int i = 0; i < count; i++)
			push_command(random_command(w, h));
	endtask

	// Hold until every item is taken and every rectangle has come back
	task automatic settle();
		while (cmd_accepted != cmd_pushed || rect_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RES_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_source_size(input logic [RES_W-1:0] w, input logic [RES_W-1:0] h);
		settle();
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
	endtask

	// Command driver: offer queued items with random gaps
	always @(posedge clk or negedge arst_n) begin
		command_t nxt;
		if (!arst_n) begin
			cmd.valid     <= 1'b0;
			cmd.word_high <= '0;
			cmd.word_low  <= '0;
			cmd_gap       <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				decode_command(cmd.word_high, cmd.word_low);
				cmd_accepted <= cmd_accepted + 1;
			end
			if (!cmd.valid || cmd.ready) begin
				if (cmd_gap != 0) begin
					cmd.valid <= 1'b0;
					cmd_gap   <= cmd_gap - 1;
				end else if (cmd_queue.size() != 0) begin
					nxt = cmd_queue.pop_front();
					cmd.valid     <= 1'b1;
					cmd.word_high <= nxt.word_high;
					cmd.word_low  <= nxt.word_low;
					cmd_gap       <= $urandom_range(0, pace_max);
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each item against the oldest expected rectangle
	always @(posedge clk or negedge arst_n) begin
		rect_result_t want, got;
		int stall;
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_wait  <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got = '{res.left, res.top, res.right, res.bottom, res.pixel_color,
					res.pixel_total};
				results_seen <= results_seen + 1;
				if (rect_expect.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected rectangle: %p", got);
					mismatches++;
				end else begin
					want = rect_expect.pop_front();
					if (got !== want) begin
						if (mismatches < MAX_REPORTS)
							$display("rectangle mismatch: expected %p, actual %p", want, got);
						mismatches++;
					end
				end
				stall = $urandom_range(0, pace_max);
				res_wait  <= stall;
				res.ready <= (stall == 0) && (hold_cycles == 0);
			end else if (hold_cycles != 0) begin
				res.ready <= 1'b0;
			end else if (res_wait != 0) begin
				res_wait  <= res_wait - 1;
				res.ready <= (res_wait == 1);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, once, so the block backs up onto its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AT) begin
			hold_cycles <= HOLD_LEN;
			hold_done   <= 1'b1;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Mirror register writes
	always @(posedge clk) begin
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SOURCE_WIDTH:  src_width  <= cfg.data;
				REG_SOURCE_HEIGHT: src_height <= cfg.data;
				default: ;
			endcase
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready) ||
					(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		logic [RES_W-1:0] w, h;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands at the reset source size
		push_command(rect_command(0, 0, 0, 0, 1'b0));
		push_command('{{OP_PRIM_COLOR, 24'hFF_FFFF}, 32'hFFFF_FFFF});
		push_command(rect_command(319, 239, 0, 0, 1'b0));
		push_command(rect_command(1023, 1023, 0, 0, 1'b1));
		push_command(rect_command(1023, 1023, 1023, 1023, 1'b0));
		push_command(rect_command(50, 100, 100, 20, 1'b0));
		push_command(rect_command(319, 100, 300, 101, 1'b0));
		push_command('{{OP_FILL_COLOR, 24'h0}, 32'h0000_FFFF});
		push_command('{CYCLE_WORD, CYCLE_FILL});
		push_command(rect_command(319, 239, 319, 239, 1'b1));
		push_command('{{OP_FILL_COLOR, 24'hFF_FFFF}, 32'hFFFF_0001});
		push_command(rect_command(10, 20, 5, 6, 1'b0));
		push_command('{CYCLE_WORD, CYCLE_FILL | 32'h1});
		push_command(rect_command(200, 150, 100, 50, 1'b0));
		push_command('{CYCLE_WORD & 32'hFFFF_FFFE, CYCLE_FILL});
		push_command('{{OP_PRIM_COLOR, 24'h0}, 32'h1234_56FF});
		push_command(rect_command(64, 48, 32, 16, 1'b0));
		push_command('{32'h0, 32'h0});
		push_command('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		push_command(rect_command(1023, 1023, 0, 0, 1'b0));
		push_random(140, SOURCE_WIDTH_RST, SOURCE_HEIGHT_RST);

		// Zero resolution maps corners unchanged
		set_source_size(10'd0, 10'd0);
		push_command(rect_command(319, 239, 0, 0, 1'b0));
		push_command(rect_command(1023, 1023, 319, 239, 1'b0));
		push_command(rect_command(400, 10, 320, 0, 1'b0));
		push_random(100, 10'd0, 10'd0);

		set_source_size(10'd1023, 10'd1023);
		push_command(rect_command(1023, 1023, 0, 0, 1'b0));
		push_random(100, 10'd1023, 10'd1023);

		set_source_size(10'd1, 10'd1);
		push_command(rect_command(1, 1, 0, 0, 1'b0));
		push_command(rect_command(1, 1, 1, 0, 1'b0));
		push_random(60, 10'd1, 10'd1);

		// Back-to-back stretch with no idling on either side
		set_source_size(10'd640, 10'd480);
		pace_max = 0;
		push_random(120, 10'd640, 10'd480);

		for (int p = 0; p < 3; p++) begin
			w = $urandom_range(0, 1023);
			h = $urandom_range(0, 1023);
			set_source_size(w, h);
			pace_max = 17;
			push_random(80, w, h);
		end

		set_source_size(10'd320, 10'd240);
		push_random(100, 10'd320, 10'd240);

		settle();
		if (mismatches == 0 && rect_expect.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
design/dlfr_pkg.sv
design/dlfr_if.sv
design/dlfr_ctrl.sv
design/dlfr_dpath.sv
design/display_list_fill_rect_decoder.sv
design/dlfr_chk.sv
tb/tb.sv
